>>> rtl/sharpen_convolution_3x3_stream_top_defines.svh
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream assertion macros
// Shared property templates for the checker of the sharpen stream filter.
// ----------------------------------------------------------------------------
`ifndef SHARPEN_CONVOLUTION_3X3_STREAM_TOP_DEFINES_SVH
`define SHARPEN_CONVOLUTION_3X3_STREAM_TOP_DEFINES_SVH

// Same-cycle implication with an explicit disable condition.
`define SC3_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sc3 assertion failed");

// Next-cycle implication with an explicit disable condition.
`define SC3_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sc3 assertion failed");

`endif

>>> rtl/sc3_pkg.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream package
// Types, register indexes and constants shared by the sharpen filter modules.
// ----------------------------------------------------------------------------
package sc3_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WCFG_W     = 13;
    localparam int HCFG_W     = 16;
    localparam int ROW_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic              COLOR_MODE_RST   = 1'b1;
    localparam logic [WCFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [HCFG_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [7:0] t_sample;

    typedef struct packed {
        t_sample ch2;
        t_sample ch1;
        t_sample ch0;
    } t_pix;

    typedef struct packed {
        logic    req_type;
        t_sample pix_ch0;
        t_sample pix_ch1;
        t_sample pix_ch2;
    } t_in_item;

    typedef struct packed {
        t_sample out_ch0;
        t_sample out_ch1;
        t_sample out_ch2;
        logic    frame_end;
    } t_out_item;

    typedef struct packed {
        logic rgb;
        logic emit;
        logic frame_end;
        logic mask_u;
        logic mask_d;
        logic mask_l;
        logic r_zero;
    } t_cmd_ctl;

endpackage

>>> rtl/sc3_front.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream front end
// Holds the configuration and raster position, accepts requests and turns each
// pixel, or flush past the last row, into a line store command with edge masks
// ----------------------------------------------------------------------------
module sc3_front
    import sc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  t_in_item                      i_in_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_cmd_addr,
    output t_pix                          o_cmd_pix,
    output t_cmd_ctl                      o_cmd_ctl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic              r_color_mode;
    logic [WCFG_W-1:0] r_image_width;
    logic [HCFG_W-1:0] r_image_height;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;

    logic [WW-1:0]     eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [ROW_W-1:0]  h_m1;
    logic [CW-1:0]     ic;
    logic              ic_nz;
    logic              pending;
    logic              is_pixel;
    logic              accept;
    logic              process;
    logic              out_valid;
    logic [ROW_W-1:0]  row_back;
    logic [ROW_W-1:0]  orow;
    logic [CW-1:0]     ocol;
    logic              frame_end;
    logic [WW-1:0]     col_inc;

    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_image_width);
        end
        eff_h = (r_image_height == '0) ? ROW_W'(1) : ROW_W'(r_image_height);
        h_m1  = eff_h - ROW_W'(1);

        ic       = (WW'(r_col) >= eff_w) ? '0 : r_col;
        ic_nz    = (ic != '0);
        pending  = (r_row >= eff_h);
        is_pixel = (i_in_data.req_type == REQ_PIXEL);
        accept   = i_in_valid && !i_q_full;
        process  = pending || is_pixel;

        out_valid = ic_nz ? (r_row >= ROW_W'(1)) : (r_row >= ROW_W'(2));
        row_back  = out_valid ? (ic_nz ? ROW_W'(1) : ROW_W'(2)) : '0;
        orow      = r_row - row_back;
        ocol      = ic_nz ? (ic - CW'(1)) : CW'(eff_w - WW'(1));
        frame_end = out_valid && (orow == h_m1) && (WW'(ocol) == (eff_w - WW'(1)));

        col_inc = WW'(ic) + WW'(1);
        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end
    end

    always_comb begin
        o_cmd_pix = '0;
        if (is_pixel && !pending) begin
            o_cmd_pix.ch0 = i_in_data.pix_ch0;
            if (r_color_mode) begin
                o_cmd_pix.ch1 = i_in_data.pix_ch1;
                o_cmd_pix.ch2 = i_in_data.pix_ch2;
            end
        end
        o_cmd_addr          = ic;
        o_cmd_ctl.rgb       = r_color_mode;
        o_cmd_ctl.emit      = out_valid;
        o_cmd_ctl.frame_end = frame_end;
        o_cmd_ctl.mask_u    = (orow == '0);
        o_cmd_ctl.mask_d    = (orow >= h_m1);
        o_cmd_ctl.mask_l    = (ocol == '0);
        o_cmd_ctl.r_zero    = !ic_nz;
        o_push              = accept && process;
        o_in_stall          = i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode   <= COLOR_MODE_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLOR_MODE: begin
                    r_color_mode <= i_cfg_data[0];
                    r_col        <= '0;
                    r_row        <= '0;
                end
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[WCFG_W-1:0];
                    r_col         <= '0;
                    r_row         <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[HCFG_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept && process) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/sc3_queue.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream command queue
// Short first-in first-out buffer that decouples the front end from the
// line store pipeline.
// ----------------------------------------------------------------------------
module sc3_queue
    import sc3_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

>>> rtl/sc3_back.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream back end
// Line stores, the 3x3 window and the sharpen arithmetic, ending in the
// output register.
// ----------------------------------------------------------------------------
module sc3_back
    import sc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_cmd_addr,
    input  t_pix                          i_cmd_pix,
    input  t_cmd_ctl                      i_cmd_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output t_out_item                     o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    t_pix          r_up_mem  [MAX_WIDTH];
    t_pix          r_mid_mem [MAX_WIDTH];

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_addr;
    t_pix          r_s1_pix;
    t_cmd_ctl      r_s1_ctl;
    logic          r_s1_fwd;
    t_pix          r_up_rd;
    t_pix          r_mid_rd;
    t_pix          r_last_cm;

    t_pix          r_win_u;
    t_pix          r_win_c;
    t_pix          r_win_d;
    t_pix          r_win_l;

    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          adv;
    t_pix          cu;
    t_pix          cm;
    t_pix          tap_u;
    t_pix          tap_d;
    t_pix          tap_l;
    t_pix          tap_r;
    t_out_item     n_out_data;

    function automatic t_sample f_sharpen(input t_sample c, input t_sample u,
                                          input t_sample d, input t_sample l,
                                          input t_sample r);
        logic [11:0] acc;
        acc = {2'b00, c, 2'b00} + {4'b0000, c} - {4'b0000, u} - {4'b0000, d}
              - {4'b0000, l} - {4'b0000, r};
        if (acc[11]) begin
            return '0;
        end else if (acc[10:8] != '0) begin
            return 8'hFF;
        end else begin
            return acc[7:0];
        end
    endfunction

    assign adv       = !r_out_valid || !i_out_stall;
    assign o_cmd_pop = adv && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_mid_rd              <= r_mid_mem[i_cmd_addr];
            r_mid_mem[i_cmd_addr] <= i_cmd_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_up_rd <= r_up_mem[i_cmd_addr];
        end
        if (adv && r_s1_valid) begin
            r_up_mem[r_s1_addr] <= cm;
        end
    end

    always_comb begin
        cm    = r_mid_rd;
        cu    = r_s1_fwd ? r_last_cm : r_up_rd;
        tap_u = r_s1_ctl.mask_u ? '0 : r_win_u;
        tap_d = r_s1_ctl.mask_d ? '0 : r_win_d;
        tap_l = r_s1_ctl.mask_l ? '0 : r_win_l;
        tap_r = r_s1_ctl.r_zero ? '0 : cm;

        n_out_data.out_ch0   = f_sharpen(r_win_c.ch0, tap_u.ch0, tap_d.ch0, tap_l.ch0, tap_r.ch0);
        n_out_data.out_ch1   = '0;
        n_out_data.out_ch2   = '0;
        if (r_s1_ctl.rgb) begin
            n_out_data.out_ch1 = f_sharpen(r_win_c.ch1, tap_u.ch1, tap_d.ch1,
                                           tap_l.ch1, tap_r.ch1);
            n_out_data.out_ch2 = f_sharpen(r_win_c.ch2, tap_u.ch2, tap_d.ch2,
                                           tap_l.ch2, tap_r.ch2);
        end
        n_out_data.frame_end = r_s1_ctl.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_addr <= i_cmd_addr;
            r_s1_pix  <= i_cmd_pix;
            r_s1_ctl  <= i_cmd_ctl;
            r_s1_fwd  <= r_s1_valid && (i_cmd_addr == r_s1_addr);
        end
        if (adv && r_s1_valid) begin
            r_last_cm <= cm;
            r_win_u   <= cu;
            r_win_c   <= cm;
            r_win_d   <= r_s1_pix;
            r_win_l   <= r_win_c;
        end
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_cmd_valid;
            r_out_valid <= r_s1_valid && r_s1_ctl.emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/sharpen_convolution_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream filter
// Gray or RGB raster stream through a 3x3 sharpen kernel with zero borders.
// ----------------------------------------------------------------------------
// The block takes one request per clock, pixels and flush ticks alike, and
// gives at most one result per clock, as long as the output is not stalled.
// A result leaves the output register after the request completing its window
// passes the line store read stage; it is one row plus one pixel after the
// pixel itself, so W+1 flush ticks after the last pixel drain the frame. Two
// line stores of MAX_WIDTH entries, each read and written once per cycle, set
// the row limit; they need no clearing after reset. A four-entry queue between
// the request side and the line store pipeline lets either side stall.
module sharpen_convolution_3x3_stream_top
    import sc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = CW + $bits(t_pix) + $bits(t_cmd_ctl);

    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;
    logic [CW-1:0] f_addr;
    t_pix          f_pix;
    t_cmd_ctl      f_ctl;
    logic [QW-1:0] q_data;
    logic [CW-1:0] b_addr;
    t_pix          b_pix;
    t_cmd_ctl      b_ctl;

    sc3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd_addr  (f_addr),
        .o_cmd_pix   (f_pix),
        .o_cmd_ctl   (f_ctl)
    );

    sc3_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_addr, f_pix, f_ctl}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign {b_addr, b_pix, b_ctl} = q_data;

    sc3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd_addr  (b_addr),
        .i_cmd_pix   (b_pix),
        .i_cmd_ctl   (b_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/sc3_checker.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 stream checker
// Port-level properties of the sharpen filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sharpen_convolution_3x3_stream_top_defines.svh"

module sc3_checker
    import sc3_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data
);

    logic r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= !COLOR_MODE_RST;
        end else if (i_cfg_we && (i_cfg_index == CFG_COLOR_MODE)) begin
            r_gray <= !i_cfg_data[0];
        end
    end

    `SC3_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `SC3_ASSERT_NXT(a_rst_clears_out, i_clk, 1'b0, !i_rst_n, !o_out_valid)
    `SC3_ASSERT_IMP(a_gray_zero, i_clk, !i_rst_n, o_out_valid && r_gray, (o_out_data.out_ch1 == '0) && (o_out_data.out_ch2 == '0))
    `SC3_ASSERT_IMP(a_full_needs_stall, i_clk, !i_rst_n, o_in_stall, $past(i_out_stall))

endmodule

bind sharpen_convolution_3x3_stream_top sc3_checker u_checker (.*);
